FILE: src/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared constants, state encoding and controller/datapath structs for the
// fixed-priority response-time analyzer.
// ----------------------------------------------------------------------------
`default_nettype none
package frt_pkg;
   localparam int MAX_TASKS   = 64;
   localparam int PROC_BITS   = 6;
   localparam int IDX_W       = $clog2(MAX_TASKS);
   localparam int CNT_W       = $clog2(MAX_TASKS + 1);
   localparam int SPROC_W     = PROC_BITS + 1;
   localparam int ENTRY_W     = 32 + 32 + 32 + SPROC_W;
   localparam int STEP_W      = 6;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(32);
   localparam logic [33:0] MISS_MARGIN = 34'd100;
   localparam logic [33:0] SAT34 = 34'h3_FFFF_FFFF;

   localparam logic [1:0] VERDICT_MET    = 2'd0;
   localparam logic [1:0] VERDICT_MISSED = 2'd1;
   localparam logic [1:0] VERDICT_SKIP   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_READ, S_CHECK, S_DIV, S_MUL_INIT, S_MUL, S_ACC, S_EVAL, S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic skip;
      logic init;
      logic miss;
      logic conv;
      logic next;
      logic div_start;
      logic div_step;
      logic mul_start;
      logic mul_step;
      logic acc;
      logic retry;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic unassigned;
      logic start_late;
      logic k_end;
      logic proc_match;
      logic step_last;
      logic converged;
      logic resp_ok;
      logic out_free;
   } status_type;
endpackage
`default_nettype wire

FILE: src/frt_req_if.sv
// ----------------------------------------------------------------------------
// frt_req_if
// Task transaction channel: valid/ready plus the task descriptor.
// ----------------------------------------------------------------------------
`default_nettype none
interface frt_req_if;
   logic        valid;
   logic        ready;
   logic        first_of_set;
   logic [31:0] task_wcet;
   logic [31:0] task_period;
   logic [31:0] task_deadline;
   logic [31:0] task_jitter;
   logic [31:0] task_blocking;
   logic [frt_pkg::PROC_BITS-1:0] task_processor;
   logic        is_unassigned;

   modport source (output valid, first_of_set, task_wcet, task_period, task_deadline,
                   task_jitter, task_blocking, task_processor, is_unassigned,
                   input ready);
   modport sink (input valid, first_of_set, task_wcet, task_period, task_deadline,
                 task_jitter, task_blocking, task_processor, is_unassigned,
                 output ready);
endinterface
`default_nettype wire

FILE: src/frt_rsp_if.sv
// ----------------------------------------------------------------------------
// frt_rsp_if
// Result transaction channel: valid/ready plus bound, verdict and set flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface frt_rsp_if;
   logic        valid;
   logic        ready;
   logic [33:0] latency_bound;
   logic [1:0]  verdict;
   logic        all_met_so_far;

   modport source (output valid, latency_bound, verdict, all_met_so_far, input ready);
   modport sink (input valid, latency_bound, verdict, all_met_so_far, output ready);
endinterface
`default_nettype wire

FILE: src/frt_ctrl.sv
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: walks the task table, runs divide and multiply per entry on the
// same processor, evaluates the fixed point and hands the result to the
// output register.
`default_nettype none
module frt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire frt_pkg::status_type st,
   output frt_pkg::cmd_type        cmd
);
   frt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         frt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = frt_pkg::S_START;
            end
         end
         frt_pkg::S_START: begin
            if (st.unassigned) begin
               cmd.skip = 1'b1;
               state_in = frt_pkg::S_DONE;
            end else if (st.start_late) begin
               cmd.miss = 1'b1;
               state_in = frt_pkg::S_DONE;
            end else begin
               cmd.init = 1'b1;
               state_in = frt_pkg::S_READ;
            end
         end
         frt_pkg::S_READ: state_in = frt_pkg::S_CHECK;
         frt_pkg::S_CHECK: begin
            if (st.k_end) begin
               state_in = frt_pkg::S_EVAL;
            end else if (!st.proc_match) begin
               cmd.next = 1'b1;
               state_in = frt_pkg::S_READ;
            end else begin
               cmd.div_start = 1'b1;
               state_in = frt_pkg::S_DIV;
            end
         end
         frt_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.step_last) state_in = frt_pkg::S_MUL_INIT;
         end
         frt_pkg::S_MUL_INIT: begin
            cmd.mul_start = 1'b1;
            state_in = frt_pkg::S_MUL;
         end
         frt_pkg::S_MUL: begin
            cmd.mul_step = 1'b1;
            if (st.step_last) state_in = frt_pkg::S_ACC;
         end
         frt_pkg::S_ACC: begin
            cmd.acc = 1'b1;
            state_in = frt_pkg::S_READ;
         end
         frt_pkg::S_EVAL: begin
            if (st.converged) begin
               cmd.conv = 1'b1;
               state_in = frt_pkg::S_DONE;
            end else if (st.resp_ok) begin
               cmd.retry = 1'b1;
               state_in = frt_pkg::S_READ;
            end else begin
               cmd.miss = 1'b1;
               state_in = frt_pkg::S_DONE;
            end
         end
         frt_pkg::S_DONE: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in = frt_pkg::S_IDLE;
            end
         end
         default: state_in = frt_pkg::S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: src/frt_dp.sv
// ----------------------------------------------------------------------------
// frt_dp
// Datapath: task table memory, bit-serial divider and multiplier, saturating
// demand accumulator, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none
module frt_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire frt_pkg::cmd_type            cmd,
   output frt_pkg::status_type              st,
   input  wire logic                        in_first,
   input  wire logic [31:0]                 in_wcet,
   input  wire logic [31:0]                 in_period,
   input  wire logic [31:0]                 in_deadline,
   input  wire logic [31:0]                 in_jitter,
   input  wire logic [31:0]                 in_blocking,
   input  wire logic [frt_pkg::PROC_BITS-1:0] in_proc,
   input  wire logic                        in_unassigned,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [33:0]                      out_bound,
   output logic [1:0]                       out_verdict,
   output logic                             out_all_met
);
   localparam int IW = frt_pkg::IDX_W;
   localparam int CW = frt_pkg::CNT_W;
   localparam int PW = frt_pkg::SPROC_W;

   logic [frt_pkg::ENTRY_W-1:0] mem [frt_pkg::MAX_TASKS];
   logic [frt_pkg::ENTRY_W-1:0] rd_ff;

   logic [31:0] wcet_ff, period_ff, deadline_ff, jitter_ff;
   logic [32:0] start_ff;
   logic [PW-1:0] proc_ff;
   logic [CW-1:0] count_ff, k_ff;
   logic        all_met_ff;
   logic [33:0] resp_ff, sum_ff, acc_ff, bound_ff;
   logic [1:0]  verdict_ff;
   logic [31:0] div_ff, rem_ff;
   logic [32:0] quo_ff, mq_ff;
   logic [frt_pkg::STEP_W-1:0] step_ff;
   logic        out_valid_ff;
   logic [33:0] out_bound_ff;
   logic [1:0]  out_verdict_ff;
   logic        out_all_met_ff;

   logic [31:0] rd_wcet, rd_period, rd_jitter;
   logic [PW-1:0] rd_proc;
   logic [32:0] shifted, diff;
   logic        ge;
   logic [35:0] mul_t;
   logic [34:0] sum_t;
   logic [33:0] conv_bound, miss_bound;
   logic        miss_now;

   assign rd_wcet   = rd_ff[31:0];
   assign rd_period = rd_ff[63:32];
   assign rd_jitter = rd_ff[95:64];
   assign rd_proc   = rd_ff[frt_pkg::ENTRY_W-1:96];

   assign shifted = {rem_ff, quo_ff[32]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};
   assign mul_t   = {1'b0, acc_ff, 1'b0} + (mq_ff[32] ? {4'b0, rd_wcet} : 36'd0);
   assign sum_t   = {1'b0, sum_ff} + {1'b0, acc_ff};
   assign conv_bound = {1'b0, resp_ff[31:0] + {1'b0, jitter_ff}};
   assign miss_bound = {2'b0, deadline_ff} + frt_pkg::MISS_MARGIN;
   assign miss_now   = verdict_ff == frt_pkg::VERDICT_MISSED;

   always_comb begin
      st.unassigned = proc_ff[PW-1];
      st.start_late = {1'b0, start_ff} > {2'b0, deadline_ff};
      st.k_end      = k_ff >= count_ff;
      st.proc_match = rd_proc == proc_ff;
      st.step_last  = step_ff == frt_pkg::LAST_STEP;
      st.converged  = sum_ff == resp_ff;
      st.resp_ok    = sum_ff <= {2'b0, deadline_ff};
      st.out_free   = !out_valid_ff || out_ready;
   end

   // table memory, one registered read port and one write port
   always_ff @(posedge clock) begin
      rd_ff <= mem[k_ff[IW-1:0]];
      if (cmd.finish && count_ff < CW'(frt_pkg::MAX_TASKS)) begin
         mem[count_ff[IW-1:0]] <= {proc_ff, jitter_ff, period_ff, wcet_ff};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         all_met_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && in_first) begin
            count_ff   <= '0;
            all_met_ff <= 1'b1;
         end
         if (cmd.finish) begin
            if (count_ff < CW'(frt_pkg::MAX_TASKS)) count_ff <= count_ff + 1'b1;
            if (miss_now) all_met_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wcet_ff     <= in_wcet;
         period_ff   <= in_period;
         deadline_ff <= in_deadline;
         jitter_ff   <= in_jitter;
         start_ff    <= {1'b0, in_blocking} + {1'b0, in_wcet};
         proc_ff     <= {in_unassigned, in_proc};
      end
      if (cmd.init) begin
         resp_ff <= {1'b0, start_ff};
         sum_ff  <= {1'b0, start_ff};
         k_ff    <= '0;
      end
      if (cmd.retry) begin
         resp_ff <= sum_ff;
         sum_ff  <= {1'b0, start_ff};
         k_ff    <= '0;
      end
      if (cmd.next) k_ff <= k_ff + 1'b1;
      if (cmd.div_start) begin
         div_ff  <= (rd_period == 32'd0) ? 32'd1 : rd_period;
         rem_ff  <= '0;
         quo_ff  <= resp_ff[31:0] + {1'b0, rd_jitter};
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? diff[31:0] : shifted[31:0];
         quo_ff  <= {quo_ff[31:0], ge};
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.mul_start) begin
         mq_ff   <= quo_ff + {32'd0, rem_ff != 32'd0};
         acc_ff  <= '0;
         step_ff <= '0;
      end
      if (cmd.mul_step) begin
         mq_ff   <= {mq_ff[31:0], 1'b0};
         acc_ff  <= (mul_t > {2'b0, frt_pkg::SAT34}) ? frt_pkg::SAT34 : mul_t[33:0];
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.acc) begin
         sum_ff <= (sum_t > {1'b0, frt_pkg::SAT34}) ? frt_pkg::SAT34 : sum_t[33:0];
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.skip) begin
         bound_ff   <= '0;
         verdict_ff <= frt_pkg::VERDICT_SKIP;
      end
      if (cmd.miss) begin
         bound_ff   <= miss_bound;
         verdict_ff <= frt_pkg::VERDICT_MISSED;
      end
      if (cmd.conv) begin
         bound_ff   <= conv_bound;
         verdict_ff <= (conv_bound <= {2'b0, deadline_ff}) ? frt_pkg::VERDICT_MET
                                                          : frt_pkg::VERDICT_MISSED;
      end
      if (cmd.finish) begin
         out_bound_ff   <= bound_ff;
         out_verdict_ff <= verdict_ff;
         out_all_met_ff <= all_met_ff && !miss_now;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_bound   = out_bound_ff;
   assign out_verdict = out_verdict_ff;
   assign out_all_met = out_all_met_ff;
endmodule
`default_nettype wire

FILE: src/fixed_priority_response_time.sv
// ----------------------------------------------------------------------------
// fixed_priority_response_time
// Fixed-priority response-time analysis with release jitter, one task per
// transaction.
// ----------------------------------------------------------------------------
// Tasks arrive in descending priority order; each one is analyzed against the
// tasks of its set already stored on the same processor, then stored itself
// (up to 64 per set). One task is worked on at a time. Each fixed-point pass
// visits every stored entry and, for each entry on the same processor, runs
// the bit-serial divider, a multiplier setup, the bit-serial multiplier and
// the accumulate step; the pass closes with a last read, an end check and an
// evaluate. A task that is unassigned or starts past its deadline gets its
// result without any pass. A finished result waits in the output register, so
// the next task is taken while it is still pending.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_priority_response_time (
   input wire logic  clock,
   input wire logic  reset,
   frt_req_if.sink   req,
   frt_rsp_if.source rsp
);
   frt_pkg::cmd_type    cmd;
   frt_pkg::status_type st;

   // sequencer: accepts a transaction only when idle
   frt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // table, serial arithmetic, and the output register holding the result
   frt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .in_first      (req.first_of_set),
      .in_wcet       (req.task_wcet),
      .in_period     (req.task_period),
      .in_deadline   (req.task_deadline),
      .in_jitter     (req.task_jitter),
      .in_blocking   (req.task_blocking),
      .in_proc       (req.task_processor),
      .in_unassigned (req.is_unassigned),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .out_bound     (rsp.latency_bound),
      .out_verdict   (rsp.verdict),
      .out_all_met   (rsp.all_met_so_far)
   );
endmodule
`default_nettype wire

FILE: src/frt_checker.sv
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks on the response-time analyzer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module frt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [33:0] rsp_bound,
   input wire logic [1:0]  rsp_verdict,
   input wire logic        rsp_all_met
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bound))
      else $error("stalled result changed");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict == frt_pkg::VERDICT_MET ||
                    rsp_verdict == frt_pkg::VERDICT_MISSED ||
                    rsp_verdict == frt_pkg::VERDICT_SKIP)
      else $error("bad verdict code");

   a_miss_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == frt_pkg::VERDICT_MISSED |-> !rsp_all_met)
      else $error("miss reported with set flag still high");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == frt_pkg::VERDICT_SKIP |-> rsp_bound == 34'd0)
      else $error("skipped task with nonzero bound");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second task taken while busy");
endmodule

bind fixed_priority_response_time frt_checker u_frt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_bound   (rsp.latency_bound),
   .rsp_verdict (rsp.verdict),
   .rsp_all_met (rsp.all_met_so_far)
);
`default_nettype wire
